>>> design/rgbw_hue_color_classifier_core_macros.svh
// Assertion macros shared by the classifier modules.
// Each macro samples on clk and is disabled while arst_n is low.
`ifndef RGBW_HUE_COLOR_CLASSIFIER_CORE_MACROS_SVH
`define RGBW_HUE_COLOR_CLASSIFIER_CORE_MACROS_SVH

`define RHCC_ASSERT_IMPLY(LBL, ANT, CON) \
	LBL: assert property (@(posedge clk) disable iff (!arst_n) (ANT) |-> (CON)) \
		else $error("rhcc: same-cycle check failed");

`define RHCC_ASSERT_NEXT(LBL, ANT, CON) \
	LBL: assert property (@(posedge clk) disable iff (!arst_n) (ANT) |=> (CON)) \
		else $error("rhcc: next-cycle check failed");

`endif

>>> design/rhcc_pkg.sv
package rhcc_pkg;

	localparam logic [3:0] CLS_BLACK   = 4'd0;
	localparam logic [3:0] CLS_WHITE   = 4'd1;
	localparam logic [3:0] CLS_GREY    = 4'd2;
	localparam logic [3:0] CLS_RED     = 4'd3;
	localparam logic [3:0] CLS_YELLOW  = 4'd4;
	localparam logic [3:0] CLS_GREEN   = 4'd5;
	localparam logic [3:0] CLS_AZURE   = 4'd6;
	localparam logic [3:0] CLS_BLUE    = 4'd7;
	localparam logic [3:0] CLS_MAGENTA = 4'd8;

	localparam logic [1:0] SEL_RED   = 2'd0;
	localparam logic [1:0] SEL_GREEN = 2'd1;
	localparam logic [1:0] SEL_BLUE  = 2'd2;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_BLACK_LEVEL = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WHITE_LEVEL = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SAT_LIMIT   = 2'd2;

	localparam logic [15:0] BLACK_LEVEL_RST = 16'd300;
	localparam logic [15:0] WHITE_LEVEL_RST = 16'd10000;
	localparam logic [6:0]  SAT_LIMIT_RST   = 7'd15;

	localparam int SAT_SCALE = 100;

	localparam int HUE_RED_HI     = 45;
	localparam int HUE_YELLOW_HI  = 65;
	localparam int HUE_GREEN_HI   = 150;
	localparam int HUE_AZURE_HI   = 195;
	localparam int HUE_BLUE_HI    = 260;
	localparam int HUE_MAGENTA_HI = 335;
	localparam int HUE_STEP       = 60;
	localparam int HUE_GREEN_BASE = 120;
	localparam int HUE_BLUE_BASE  = 240;
	localparam int HUE_FULL       = 360;

	typedef struct packed {
		logic [15:0] black_level;
		logic [15:0] white_level;
		logic [6:0]  sat_limit_pct;
	} cfg_t;

endpackage

>>> design/rgbw_hue_color_classifier_core.sv
// A result reaches the output ports through the two front stages, the middle queue, the hue stage and the output queue.
// Throughput: one beat per cycle while full is low, set by the two-stage front end and the hue stage.
// A stall on the output fills the output queue, then the middle queue, then raises full.
// Reset is asynchronous and active low; it empties both queues and every stage.
// Reset also returns the three configuration registers to their default values.
module rgbw_hue_color_classifier_core
	import rhcc_pkg::*;
#(
	parameter int SAMPLE_BITS = 16,
	parameter int MID_DEPTH   = 4,
	parameter int OUT_DEPTH   = 4
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	output logic                    full,
	input  logic [SAMPLE_BITS-1:0]  red_count,
	input  logic [SAMPLE_BITS-1:0]  green_count,
	input  logic [SAMPLE_BITS-1:0]  blue_count,
	input  logic [SAMPLE_BITS-1:0]  white_count,
	output logic                    empty,
	input  logic                    pop,
	output logic [3:0]              color_class,
	input  logic                    cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_DATA_W-1:0]   cfg_data
);

	localparam int W     = SAMPLE_BITS;
	localparam int MID_W = 2 * W + 8;
	localparam int MCW   = $clog2(MID_DEPTH+1);
	localparam int OCW   = $clog2(OUT_DEPTH+1);

	cfg_t cfg_q;

	logic              f_valid;
	logic [3:0]        f_class;
	logic              f_need_hue;
	logic [1:0]        f_sel;
	logic [W-1:0]      f_spread;
	logic signed [W:0] f_diff;
	logic [1:0]        f_inflight;

	logic [MID_W-1:0]  mid_wdata;
	logic [MID_W-1:0]  mid_rdata;
	logic [MCW-1:0]    mid_count;
	logic [MCW:0]      mid_load;

	logic              b_take;
	logic              b_valid;
	logic [3:0]        b_class;
	logic [OCW-1:0]    out_count;
	logic              accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.black_level   <= BLACK_LEVEL_RST;
			cfg_q.white_level   <= WHITE_LEVEL_RST;
			cfg_q.sat_limit_pct <= SAT_LIMIT_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_BLACK_LEVEL: cfg_q.black_level   <= cfg_data;
				REG_WHITE_LEVEL: cfg_q.white_level   <= cfg_data;
				REG_SAT_LIMIT:   cfg_q.sat_limit_pct <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	// A beat is taken only when the middle queue has a slot for every item in flight.
	assign mid_load = {1'b0, mid_count} + (MCW+1)'(f_inflight);
	assign full     = mid_load >= (MCW+1)'(MID_DEPTH);
	assign accept   = push && !full;

	rhcc_front #(
		.W (W)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (accept),
		.red          (red_count),
		.green        (green_count),
		.blue         (blue_count),
		.white        (white_count),
		.cfg          (cfg_q),
		.out_valid    (f_valid),
		.out_class    (f_class),
		.out_need_hue (f_need_hue),
		.out_sel      (f_sel),
		.out_spread   (f_spread),
		.out_diff     (f_diff),
		.inflight     (f_inflight)
	);

	assign mid_wdata = {f_class, f_need_hue, f_sel, f_spread, f_diff};

	rhcc_fifo #(
		.WIDTH (MID_W),
		.DEPTH (MID_DEPTH)
	) u_mid_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (f_valid),
		.wr_data (mid_wdata),
		.rd_en   (b_take),
		.rd_data (mid_rdata),
		.count   (mid_count)
	);

	rhcc_back #(
		.W         (W),
		.OUT_DEPTH (OUT_DEPTH)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_avail    (mid_count != '0),
		.in_class    (mid_rdata[MID_W-1 -: 4]),
		.in_need_hue (mid_rdata[MID_W-5]),
		.in_sel      (mid_rdata[MID_W-6 -: 2]),
		.in_spread   (mid_rdata[2*W : W+1]),
		.in_diff     ($signed(mid_rdata[W:0])),
		.out_count   (out_count),
		.in_take     (b_take),
		.out_valid   (b_valid),
		.out_class   (b_class)
	);

	rhcc_fifo #(
		.WIDTH (4),
		.DEPTH (OUT_DEPTH)
	) u_out_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (b_valid),
		.wr_data (b_class),
		.rd_en   (pop && !empty),
		.rd_data (color_class),
		.count   (out_count)
	);

	assign empty = out_count == '0;

endmodule

>>> design/rhcc_fifo.sv
`include "rgbw_hue_color_classifier_core_macros.svh"

module rhcc_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         wr_en,
	input  logic [WIDTH-1:0]             wr_data,
	input  logic                         rd_en,
	output logic [WIDTH-1:0]             rd_data,
	output logic [$clog2(DEPTH+1)-1:0]   count
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH+1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({wr_en, rd_en})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				2'b00, 2'b11: count_q <= count_q;
			endcase
		end
	end

	assign rd_data = mem_q[rd_ptr_q];
	assign count   = count_q;

	`RHCC_ASSERT_IMPLY(a_no_overflow, wr_en, count_q != CW'(DEPTH))
	`RHCC_ASSERT_IMPLY(a_no_underflow, rd_en, count_q != '0)

endmodule

>>> design/rhcc_front.sv
`include "rgbw_hue_color_classifier_core_macros.svh"

module rhcc_front
	import rhcc_pkg::*;
#(
	parameter int W = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic [W-1:0]        red,
	input  logic [W-1:0]        green,
	input  logic [W-1:0]        blue,
	input  logic [W-1:0]        white,
	input  cfg_t                cfg,
	output logic                out_valid,
	output logic [3:0]          out_class,
	output logic                out_need_hue,
	output logic [1:0]          out_sel,
	output logic [W-1:0]        out_spread,
	output logic signed [W:0]   out_diff,
	output logic [1:0]          inflight
);

	localparam int CW = (W > 16) ? W : 16;
	localparam int PW = W + 7;

	logic [1:0]   sel_c;
	logic [W-1:0] mx_c;
	logic [W-1:0] mn_c;
	logic         black_c;
	logic         white_c;

	logic         v_s1;
	logic [1:0]   sel_s1;
	logic [W-1:0] mx_s1;
	logic [W-1:0] mn_s1;
	logic [W-1:0] r_s1;
	logic [W-1:0] g_s1;
	logic [W-1:0] b_s1;
	logic         black_s1;
	logic         white_s1;

	logic               v_s2;
	logic [1:0]         sel_s2;
	logic [W-1:0]       mx_s2;
	logic [W-1:0]       spread_s2;
	logic signed [W:0]  diff_s2;
	logic               black_s2;
	logic               white_s2;

	logic signed [W:0]  diff_c;
	logic [PW-1:0]      sat_prod;
	logic [PW-1:0]      lim_prod;
	logic               achrom;

	// Ties in the maximum favor red, then green.
	always_comb begin
		if ((red >= green) && (red >= blue)) begin
			sel_c = SEL_RED;
			mx_c  = red;
		end else if (green >= blue) begin
			sel_c = SEL_GREEN;
			mx_c  = green;
		end else begin
			sel_c = SEL_BLUE;
			mx_c  = blue;
		end
		if ((red <= green) && (red <= blue)) begin
			mn_c = red;
		end else if (green <= blue) begin
			mn_c = green;
		end else begin
			mn_c = blue;
		end
		black_c = CW'(white) < CW'(cfg.black_level);
		white_c = CW'(white) > CW'(cfg.white_level);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		sel_s1   <= sel_c;
		mx_s1    <= mx_c;
		mn_s1    <= mn_c;
		r_s1     <= red;
		g_s1     <= green;
		b_s1     <= blue;
		black_s1 <= black_c;
		white_s1 <= white_c;
	end

	always_comb begin
		unique case (sel_s1)
			SEL_RED:   diff_c = $signed({1'b0, g_s1}) - $signed({1'b0, b_s1});
			SEL_GREEN: diff_c = $signed({1'b0, b_s1}) - $signed({1'b0, r_s1});
			SEL_BLUE:  diff_c = $signed({1'b0, r_s1}) - $signed({1'b0, g_s1});
			default:   diff_c = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		sel_s2    <= sel_s1;
		mx_s2     <= mx_s1;
		spread_s2 <= mx_s1 - mn_s1;
		diff_s2   <= diff_c;
		black_s2  <= black_s1;
		white_s2  <= white_s1;
	end

	// A zero maximum counts as zero saturation.
	always_comb begin
		sat_prod = PW'(spread_s2) * PW'(SAT_SCALE);
		lim_prod = PW'(mx_s2) * PW'(cfg.sat_limit_pct);
		achrom   = (sat_prod < lim_prod) ||
			((mx_s2 == '0) && (cfg.sat_limit_pct != '0));
		out_need_hue = 1'b0;
		priority if (black_s2) begin
			out_class = CLS_BLACK;
		end else if (achrom) begin
			out_class = white_s2 ? CLS_WHITE : CLS_GREY;
		end else if (spread_s2 == '0) begin
			out_class = CLS_RED;
		end else begin
			out_class    = CLS_RED;
			out_need_hue = 1'b1;
		end
	end

	assign out_valid  = v_s2;
	assign out_sel    = sel_s2;
	assign out_spread = spread_s2;
	assign out_diff   = diff_s2;
	assign inflight   = {1'b0, v_s1} + {1'b0, v_s2};

	`RHCC_ASSERT_IMPLY(a_zero_max_no_hue, v_s2 && (mx_s2 == '0), !out_need_hue)
	`RHCC_ASSERT_NEXT(a_stage_advance, in_valid, v_s1)

endmodule

>>> design/rhcc_back.sv
`include "rgbw_hue_color_classifier_core_macros.svh"

module rhcc_back
	import rhcc_pkg::*;
#(
	parameter int W         = 16,
	parameter int OUT_DEPTH = 4
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_avail,
	input  logic [3:0]                       in_class,
	input  logic                             in_need_hue,
	input  logic [1:0]                       in_sel,
	input  logic [W-1:0]                     in_spread,
	input  logic signed [W:0]                in_diff,
	input  logic [$clog2(OUT_DEPTH+1)-1:0]   out_count,
	output logic                             in_take,
	output logic                             out_valid,
	output logic [3:0]                       out_class
);

	localparam int OCW = $clog2(OUT_DEPTH+1);
	localparam int HW  = W + 10;
	localparam int HN  = W + 9;

	logic signed [HW-1:0] diff_x;
	logic signed [HW-1:0] spread_x;
	logic signed [HW-1:0] t60;
	logic signed [HW-1:0] base;
	logic signed [HW-1:0] hsum;
	logic [OCW:0]         room_sum;

	logic          v_s1;
	logic [3:0]    class_s1;
	logic          need_s1;
	logic [W-1:0]  spread_s1;
	logic [HN-1:0] hnum_s1;

	logic [HN-1:0] sp_x;
	logic [3:0]    band;

	assign room_sum = {1'b0, out_count} + (OCW+1)'(v_s1);
	assign in_take  = in_avail && (room_sum < (OCW+1)'(OUT_DEPTH));

	// The hue numerator is hue times spread, kept in [0, 360 * spread).
	always_comb begin
		diff_x   = {{(HW-W-1){in_diff[W]}}, in_diff};
		spread_x = $signed(HW'(in_spread));
		t60      = diff_x * HW'(HUE_STEP);
		unique case (in_sel)
			SEL_RED:   base = t60[HW-1] ? spread_x * HW'(HUE_FULL) : '0;
			SEL_GREEN: base = spread_x * HW'(HUE_GREEN_BASE);
			SEL_BLUE:  base = spread_x * HW'(HUE_BLUE_BASE);
			default:   base = '0;
		endcase
		hsum = t60 + base;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= in_take;
		end
	end

	always_ff @(posedge clk) begin
		class_s1  <= in_class;
		need_s1   <= in_need_hue;
		spread_s1 <= in_spread;
		hnum_s1   <= hsum[HN-1:0];
	end

	always_comb begin
		sp_x = HN'(spread_s1);
		priority if ((hnum_s1 <= sp_x * HN'(HUE_RED_HI)) ||
			(hnum_s1 >= sp_x * HN'(HUE_MAGENTA_HI))) begin
			band = CLS_RED;
		end else if (hnum_s1 <= sp_x * HN'(HUE_YELLOW_HI)) begin
			band = CLS_YELLOW;
		end else if (hnum_s1 <= sp_x * HN'(HUE_GREEN_HI)) begin
			band = CLS_GREEN;
		end else if (hnum_s1 <= sp_x * HN'(HUE_AZURE_HI)) begin
			band = CLS_AZURE;
		end else if (hnum_s1 <= sp_x * HN'(HUE_BLUE_HI)) begin
			band = CLS_BLUE;
		end else begin
			band = CLS_MAGENTA;
		end
	end

	assign out_valid = v_s1;
	assign out_class = need_s1 ? band : class_s1;

	`RHCC_ASSERT_IMPLY(a_hue_class_range, v_s1 && need_s1,
		(out_class >= CLS_RED) && (out_class <= CLS_MAGENTA))
	`RHCC_ASSERT_IMPLY(a_out_credit, in_take, out_count != OCW'(OUT_DEPTH))

endmodule
